// ----- rtl/pfm_pkg.sv -----
// Shared constants, types and reduction helpers for the prime field multiplier.
`timescale 1ns / 1ps
package pfm_pkg;

  localparam int LIMB_W = 52;
  localparam int HALF_W = 26;
  localparam int PROD_W = 2 * LIMB_W;
  localparam int N_LIMB = 5;
  localparam int ACC_W  = 112;
  // Two multiplier stages plus nine reduction stages including the output register.
  localparam int N_STG  = 11;
  localparam int RED_STG = N_STG - 2;

  typedef logic [LIMB_W-1:0] limb_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [ACC_W-1:0]  acc_t;

  // Everything one item carries through the reduction stages.
  typedef struct packed {
    acc_t        s0;
    acc_t        s1;
    acc_t        s2;
    acc_t        s3;
    acc_t        s4;
    acc_t        s5;
    acc_t        s6;
    acc_t        s7;
    prod_t       p44;
    acc_t        d;
    acc_t        c;
    limb_t       t3;
    logic [47:0] t4;
    logic [3:0]  tx;
    limb_t       r0;
    limb_t       r1;
    limb_t       r2;
    limb_t       r3;
    limb_t       r4;
  } red_t;

  // R = 0x1000003D10 = 2^36 + 0x3D10, so every multiply by R is a shift plus
  // a multiply by a 14-bit constant.
  function automatic acc_t mul_r(input logic [63:0] x);
    acc_t xe;
    xe = ACC_W'(x);
    return (xe << 36) + xe * ACC_W'(14'h3D10);
  endfunction

  function automatic acc_t mul_r_hi(input logic [63:0] x);
    acc_t xe;
    xe = ACC_W'(x);
    return (xe << 48) + xe * ACC_W'(26'h3D10000);
  endfunction

  function automatic acc_t mul_r_lo(input logic [63:0] x);
    acc_t xe;
    xe = ACC_W'(x);
    return (xe << 32) + xe * ACC_W'(10'h3D1);
  endfunction

endpackage

// ----- rtl/pfm_mul.sv -----
// Two-stage array of the 25 limb products, built from 26x26 partial products.
`timescale 1ns / 1ps
module pfm_mul
  import pfm_pkg::*;
(
  input  logic              clk_i,
  input  logic [1:0]        en_i,
  input  limb_t             a_i [N_LIMB],
  input  limb_t             b_i [N_LIMB],
  output prod_t             prod_o [N_LIMB][N_LIMB]
);

  // Partial products per pair: hh, hl, lh, ll.
  logic [LIMB_W-1:0] pp_q [N_LIMB][N_LIMB][4];
  prod_t             prod_q [N_LIMB][N_LIMB];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < N_LIMB; i++) begin
      for (int j = 0; j < N_LIMB; j++) begin
        if (en_i[0]) begin
          pp_q[i][j][0] <= a_i[i][LIMB_W-1:HALF_W] * b_i[j][LIMB_W-1:HALF_W];
          pp_q[i][j][1] <= a_i[i][LIMB_W-1:HALF_W] * b_i[j][HALF_W-1:0];
          pp_q[i][j][2] <= a_i[i][HALF_W-1:0] * b_i[j][LIMB_W-1:HALF_W];
          pp_q[i][j][3] <= a_i[i][HALF_W-1:0] * b_i[j][HALF_W-1:0];
        end
        if (en_i[1]) begin
          prod_q[i][j] <= (PROD_W'(pp_q[i][j][0]) << LIMB_W)
                        + ((PROD_W'(pp_q[i][j][1]) + PROD_W'(pp_q[i][j][2])) << HALF_W)
                        + PROD_W'(pp_q[i][j][3]);
        end
      end
    end
  end

  assign prod_o = prod_q;

endmodule

// ----- rtl/pfm_reduce.sv -----
// Column sums and the carry and fold chain that reduces the product mod p.
`timescale 1ns / 1ps
module pfm_reduce
  import pfm_pkg::*;
(
  input  logic               clk_i,
  input  logic [RED_STG-1:0] en_i,
  input  prod_t              prod_i [N_LIMB][N_LIMB],
  output limb_t              p_o [N_LIMB]
);

  red_t st_q [RED_STG];
  red_t st_d [RED_STG];

  always_comb begin
    red_t  s;
    acc_t  u0;
    // Column sums and the top product.
    s     = st_q[0];
    s.s0  = ACC_W'(prod_i[0][0]);
    s.s1  = ACC_W'(prod_i[0][1]) + ACC_W'(prod_i[1][0]);
    s.s2  = ACC_W'(prod_i[0][2]) + ACC_W'(prod_i[1][1]) + ACC_W'(prod_i[2][0]);
    s.s3  = ACC_W'(prod_i[0][3]) + ACC_W'(prod_i[1][2]) + ACC_W'(prod_i[2][1])
          + ACC_W'(prod_i[3][0]);
    s.s4  = ACC_W'(prod_i[0][4]) + ACC_W'(prod_i[1][3]) + ACC_W'(prod_i[2][2])
          + ACC_W'(prod_i[3][1]) + ACC_W'(prod_i[4][0]);
    s.s5  = ACC_W'(prod_i[1][4]) + ACC_W'(prod_i[2][3]) + ACC_W'(prod_i[3][2])
          + ACC_W'(prod_i[4][1]);
    s.s6  = ACC_W'(prod_i[2][4]) + ACC_W'(prod_i[3][3]) + ACC_W'(prod_i[4][2]);
    s.s7  = ACC_W'(prod_i[3][4]) + ACC_W'(prod_i[4][3]);
    s.p44 = prod_i[4][4];
    st_d[0] = s;

    // Limb 3 column with the low 64 bits of the top product folded in.
    s   = st_q[0];
    s.d = s.s3 + mul_r(s.p44[63:0]);
    s.t3 = s.d[LIMB_W-1:0];
    s.d = s.d >> LIMB_W;
    st_d[1] = s;

    // Limb 4 column with the rest of the top product; split off the top 4 bits.
    s   = st_q[1];
    s.d = s.d + s.s4 + mul_r_hi(64'(s.p44[PROD_W-1:64]));
    s.t4 = s.d[47:0];
    s.tx = s.d[51:48];
    s.d = s.d >> LIMB_W;
    st_d[2] = s;

    // Limb 5 column folds into limb 0.
    s   = st_q[2];
    s.d = s.d + s.s5;
    u0  = {s.d[LIMB_W-1:0], s.tx} & ACC_W'({(LIMB_W + 4){1'b1}});
    s.c = s.s0 + mul_r_lo(u0[63:0]);
    s.r0 = s.c[LIMB_W-1:0];
    s.c = s.c >> LIMB_W;
    s.d = s.d >> LIMB_W;
    st_d[3] = s;

    s   = st_q[3];
    s.d = s.d + s.s6;
    st_d[4] = s;

    // Limb 6 column folds into limb 1.
    s   = st_q[4];
    s.c = s.c + s.s1 + mul_r(64'(s.d[LIMB_W-1:0]));
    s.r1 = s.c[LIMB_W-1:0];
    s.c = s.c >> LIMB_W;
    s.d = s.d >> LIMB_W;
    st_d[5] = s;

    s   = st_q[5];
    s.d = s.d + s.s7;
    s.c = s.c + s.s2;
    st_d[6] = s;

    // Low 64 bits of the upper columns fold into limb 2.
    s   = st_q[6];
    s.c = s.c + mul_r(s.d[63:0]);
    s.r2 = s.c[LIMB_W-1:0];
    s.c = s.c >> LIMB_W;
    s.d = s.d >> 64;
    st_d[7] = s;

    // Remaining upper bits fold into limb 3, carry into limb 4.
    s   = st_q[7];
    s.c = s.c + mul_r_hi(s.d[63:0]) + ACC_W'(s.t3);
    s.r3 = s.c[LIMB_W-1:0];
    s.c = s.c >> LIMB_W;
    s.r4 = s.c[LIMB_W-1:0] + LIMB_W'(s.t4);
    st_d[8] = s;
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < RED_STG; k++) begin
      if (en_i[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign p_o[0] = st_q[RED_STG-1].r0;
  assign p_o[1] = st_q[RED_STG-1].r1;
  assign p_o[2] = st_q[RED_STG-1].r2;
  assign p_o[3] = st_q[RED_STG-1].r3;
  assign p_o[4] = st_q[RED_STG-1].r4;

endmodule

// ----- rtl/prime_field_multiplier.sv -----
// Top level of the pipelined secp256k1 field multiplier with stream handshakes.
//
//   Channel  Dir  Payload                                   Handshake
//   s_axis   in   tdata: a_limb0..4, b_limb0..4 (520 bits)   tvalid/tready
//   m_axis   out  tdata: p_limb0..4 (260 bits, zero padded)  tvalid/tready
//
// One item is accepted per cycle unless an output stall has filled every stage.
// The pipeline has two multiplier stages (26x26 partial products, then sums)
// and nine stages of the carry and fold chain, the last being the output register.
// Each stage loads when it is empty or the stage after it moves, so a stall at
// the output fills bubbles before input ready drops. Reset clears only valid bits.
`timescale 1ns / 1ps
module prime_field_multiplier
  import pfm_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // a_limb0, a_limb1, a_limb2, a_limb3, a_limb4, b_limb0, ..., b_limb4 from bit 0 up.
  input  logic [519:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // p_limb0, p_limb1, p_limb2, p_limb3, p_limb4 from bit 0 up, then 4 zero bits.
  output logic [263:0] m_axis_tdata
);

  logic [N_STG-1:0] vld_q;
  logic [N_STG-1:0] vld_d;
  logic [N_STG-1:0] en;
  limb_t            a [N_LIMB];
  limb_t            b [N_LIMB];
  prod_t            prod [N_LIMB][N_LIMB];
  limb_t            p [N_LIMB];

  always_comb begin
    logic room;
    room = m_axis_tready;
    for (int k = N_STG - 1; k >= 0; k--) begin
      room  = room | ~vld_q[k];
      en[k] = room;
    end
  end

  // Each stage takes the valid bit of the stage before it; stage 0 takes the input.
  assign vld_d = {vld_q[N_STG-2:0], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < N_STG; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  for (genvar i = 0; i < N_LIMB; i++) begin : g_unpack
    assign a[i] = s_axis_tdata[i*LIMB_W +: LIMB_W];
    assign b[i] = s_axis_tdata[(i + N_LIMB)*LIMB_W +: LIMB_W];
    assign m_axis_tdata[i*LIMB_W +: LIMB_W] = p[i];
  end

  assign m_axis_tdata[263:260] = '0;

  pfm_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (en[1:0]),
    .a_i    (a),
    .b_i    (b),
    .prod_o (prod)
  );

  pfm_reduce u_reduce (
    .clk_i  (clk_i),
    .en_i   (en[N_STG-1:2]),
    .prod_i (prod),
    .p_o    (p)
  );

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[N_STG-1];

endmodule

// ----- tb/sv/prime_field_multiplier_test.sv -----
// Self-checking testbench for the pipelined secp256k1 field multiplier.
`timescale 1ns / 1ps
module prime_field_multiplier_test
  import pfm_pkg::*;
();

  localparam limb_t LIMB_MAX = 52'hF_FFFF_FFFF_FFFF;
  localparam logic [127:0] RED_K = 128'h10_0000_3D10;
  localparam logic [51:0] P_LIMB0 = 52'hF_FFFE_FFFF_FC2F;
  localparam logic [51:0] P_LIMB4 = 52'h0_FFFF_FFFF_FFFF;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT = 2000;

  typedef limb_t elem_t [N_LIMB];

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [519:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [263:0] m_axis_tdata;

  logic [259:0] product_q[$];
  int n_errors = 0;
  int idle_cycles = 0;

  prime_field_multiplier u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Split 5x52 schedule with two 128-bit accumulators; all shifts are exact here.
  function automatic logic [259:0] field_product(input elem_t a, input elem_t b);
    logic [127:0] c;
    logic [127:0] d;
    logic [63:0] t3, t4, tx, u0, r0, r1, r2, r3, r4, w;
    d = 0;
    d += a[0] * 128'(b[3]) + a[1] * 128'(b[2]) + a[2] * 128'(b[1]) + a[3] * 128'(b[0]);
    c = a[4] * 128'(b[4]);
    d += RED_K * c[63:0];
    c = c >> 64;
    t3 = 64'(d & LIMB_MAX); d = d >> 52;
    d += a[0] * 128'(b[4]) + a[1] * 128'(b[3]) + a[2] * 128'(b[2])
       + a[3] * 128'(b[1]) + a[4] * 128'(b[0]);
    d += (RED_K << 12) * c[63:0];
    t4 = 64'(d & LIMB_MAX); d = d >> 52;
    tx = t4 >> 48;
    t4 &= 64'hFFFF_FFFF_FFFF;
    c = a[0] * 128'(b[0]);
    d += a[1] * 128'(b[4]) + a[2] * 128'(b[3]) + a[3] * 128'(b[2]) + a[4] * 128'(b[1]);
    u0 = 64'(d & LIMB_MAX); d = d >> 52;
    u0 = (u0 << 4) | tx;
    c += 128'(u0) * (RED_K >> 4);
    r0 = 64'(c & LIMB_MAX); c = c >> 52;
    c += a[0] * 128'(b[1]) + a[1] * 128'(b[0]);
    d += a[2] * 128'(b[4]) + a[3] * 128'(b[3]) + a[4] * 128'(b[2]);
    w = 64'(d & LIMB_MAX); d = d >> 52;
    c += 128'(w) * RED_K;
    r1 = 64'(c & LIMB_MAX); c = c >> 52;
    c += a[0] * 128'(b[2]) + a[1] * 128'(b[1]) + a[2] * 128'(b[0]);
    d += a[3] * 128'(b[4]) + a[4] * 128'(b[3]);
    c += RED_K * d[63:0];
    d = d >> 64;
    r2 = 64'(c & LIMB_MAX); c = c >> 52;
    c += (RED_K << 12) * d[63:0];
    c += 128'(t3);
    r3 = 64'(c & LIMB_MAX); c = c >> 52;
    r4 = c[63:0] + t4;
    return {r4[51:0], r3[51:0], r2[51:0], r1[51:0], r0[51:0]};
  endfunction

  // Valid stays high after the item; the next gap or the next item takes it over.
  task automatic send_pair(input elem_t a, input elem_t b);
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {b[4], b[3], b[2], b[1], b[0], a[4], a[3], a[2], a[1], a[0]};
    product_q.push_back(field_product(a, b));
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic limb_t random_limb();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return LIMB_MAX;
      2: return limb_t'($urandom_range(0, 15));
      3: return LIMB_MAX - limb_t'($urandom_range(0, 15));
      default: return limb_t'({$urandom, $urandom});
    endcase
  endfunction

  task automatic test_directed();
    elem_t a, b, p_elem;
    p_elem = '{P_LIMB0, LIMB_MAX, LIMB_MAX, LIMB_MAX, P_LIMB4};
    a = '{default: '0}; b = '{default: '0};
    send_pair(a, b);
    a = '{default: LIMB_MAX}; b = '{default: LIMB_MAX};
    send_pair(a, b);
    a = '{52'd1, '0, '0, '0, '0};
    send_pair(a, b);
    send_pair(p_elem, b);
    send_pair(p_elem, p_elem);
    // Single limb pairs: each limb i against limb 4 - i and against limb i, full width.
    for (int i = 0; i < N_LIMB; i++) begin
      a = '{default: '0}; b = '{default: '0};
      a[i] = LIMB_MAX; b[N_LIMB - 1 - i] = LIMB_MAX;
      send_pair(a, b);
      b = '{default: '0}; b[i] = LIMB_MAX;
      send_pair(a, b);
    end
    // Full-width limb 4 against small values.
    a = '{52'd3, '0, '0, '0, LIMB_MAX}; b = '{52'd7, 52'd1, '0, '0, LIMB_MAX};
    send_pair(a, b);
    a = '{LIMB_MAX, LIMB_MAX, LIMB_MAX, LIMB_MAX, P_LIMB4};
    send_pair(a, a);
  endtask

  task automatic test_random(input int count);
    elem_t a, b;
    for (int n = 0; n < count; n++) begin
      foreach (a[i]) a[i] = random_limb();
      foreach (b[i]) b[i] = random_limb();
      send_pair(a, b);
    end
  endtask

  task automatic test_drain_pause();
    s_axis_tvalid <= 1'b0;
    while (product_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_back_to_back(input int count);
    elem_t a, b;
    for (int n = 0; n < count; n++) begin
      foreach (a[i]) a[i] = limb_t'({$urandom, $urandom});
      foreach (b[i]) b[i] = limb_t'({$urandom, $urandom});
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= {b[4], b[3], b[2], b[1], b[0], a[4], a[3], a[2], a[1], a[0]};
      product_q.push_back(field_product(a, b));
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      @(negedge clk_i);
    end
  endtask

  // Receiver: stalls drawn per item, with runs of no stalling.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    logic [259:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (product_q.size() == 0) begin
        $display("%0t: unexpected product %h", $time, m_axis_tdata);
        n_errors++;
      end else begin
        want = product_q.pop_front();
        for (int i = 0; i < N_LIMB; i++)
          if (m_axis_tdata[i*LIMB_W +: LIMB_W] !== want[i*LIMB_W +: LIMB_W]) begin
            $display("%0t: p_limb%0d expected %h actual %h", $time, i,
                     want[i*LIMB_W +: LIMB_W], m_axis_tdata[i*LIMB_W +: LIMB_W]);
            n_errors++;
          end
        if (m_axis_tdata[263:260] !== 4'b0) begin
          $display("%0t: padding expected 0 actual %h", $time, m_axis_tdata[263:260]);
          n_errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("prime_field_multiplier_test: errors");
      $finish;
    end
  end

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    rst_ni = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(500);
    test_drain_pause();
    test_back_to_back(100);
    test_random(600);
    test_drain_pause();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (n_errors == 0 && product_q.size() == 0)
      $display("prime_field_multiplier_test: clean");
    else
      $display("prime_field_multiplier_test: errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/pfm_pkg.sv
rtl/pfm_mul.sv
rtl/pfm_reduce.sv
rtl/prime_field_multiplier.sv
tb/sv/prime_field_multiplier_test.sv
